@@ rtl/i2cdcm_pkg.sv @@
package i2cdcm_pkg;

   // bus phases of the write sequencer
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_WAIT     = 4'd1,
      PH_START_A  = 4'd2,
      PH_START_B  = 4'd3,
      PH_START_C  = 4'd4,
      PH_BIT_LOW  = 4'd5,
      PH_BIT_HIGH = 4'd6,
      PH_ACK_LOW  = 4'd7,
      PH_ACK_HIGH = 4'd8,
      PH_STOP_A   = 4'd9,
      PH_STOP_B   = 4'd10,
      PH_STOP_C   = 4'd11
   } phase_type;

   // header progress within a transaction
   typedef enum logic [1:0] {
      HDR_ADDRESS = 2'd0,
      HDR_CONTROL = 2'd1,
      HDR_PAYLOAD = 2'd2
   } header_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_DEVICE_ADDRESS = 3'd0,
      CSR_HALF_PERIOD    = 3'd1,
      CSR_STRETCH_LIMIT  = 3'd2,
      CSR_STRETCH_ENABLE = 3'd3,
      CSR_NACK_CHECK     = 3'd4,
      CSR_STOP_ON_ERROR  = 3'd5
   } csr_index_type;

   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [7:0]  CTRL_COMMAND           = 8'h00;
   localparam logic [7:0]  CTRL_DATA              = 8'h40;
   localparam logic [6:0]  RESET_DEVICE_ADDRESS   = 7'h3C;
   localparam logic [15:0] RESET_HALF_PERIOD      = 16'd5;
   localparam logic [15:0] RESET_STRETCH_LIMIT    = 16'd10000;
   localparam logic [15:0] ARB_COUNT_MAX          = 16'hFFFF;

   typedef struct packed {
      logic       req_valid;
      logic       func;
      logic [7:0] req_byte;
      logic       req_last;
      logic       sda_in;
      logic       scl_in;
   } req_item_type;

   typedef struct packed {
      logic        scl_pull_low;
      logic        sda_pull_low;
      logic        ready_res;
      logic        byte_done;
      logic        nack_error;
      logic        arb_lost;
      logic        stretch_expired;
      logic [15:0] arb_lost_count;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [15:0] half_period_ticks;
      logic [15:0] stretch_limit_ticks;
      logic        stretch_enable;
      logic        nack_check;
      logic        stop_on_error;
   } cfg_type;

endpackage

@@ rtl/i2cdcm_fifo.sv @@
module i2cdcm_fifo
   import i2cdcm_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/i2cdcm_engine.sv @@
module i2cdcm_engine
   import i2cdcm_pkg::*;
#(
   parameter int TICK_COUNTER_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   localparam int DCW = (TICK_COUNTER_WIDTH < 16) ? TICK_COUNTER_WIDTH : 16;
   localparam logic [15:0] CMAX = (TICK_COUNTER_WIDTH >= 16) ? 16'hFFFF :
                                  16'((64'd1 << TICK_COUNTER_WIDTH) - 64'd1);

   phase_type    phase_ff, phase_in;
   logic [3:0]   bit_count_ff, bit_count_in;
   logic [7:0]   shift_ff, shift_in;
   header_type   header_ff, header_in;
   logic [7:0]   pending_payload_ff, pending_payload_in;
   logic         pending_last_ff, pending_last_in;
   logic         data_mode_ff, data_mode_in;
   logic         open_ff, open_in;
   logic [DCW-1:0] delay_ff, delay_in;
   logic [15:0]  stretch_ff, stretch_in;
   logic [15:0]  arb_total_ff, arb_total_in;

   logic [15:0]  half_nz, half_eff;
   logic [16:0]  delay_next;
   logic         released, timed, hold_low, wait_more, tmo_hit, fin;
   logic         arb_hit, do_abort;
   logic [3:0]   bit_count_inc;

   // effective half period: zero reads as one, clip to counter range
   assign half_nz  = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
   assign half_eff = (half_nz > CMAX) ? CMAX : half_nz;

   assign released = (phase_ff == PH_START_B) || (phase_ff == PH_BIT_HIGH) ||
                     (phase_ff == PH_ACK_HIGH) || (phase_ff == PH_STOP_B);
   assign timed    = (phase_ff != PH_IDLE) && (phase_ff != PH_WAIT);
   assign hold_low = timed && released && (delay_ff == '0) && cfg.stretch_enable &&
                     !item.scl_in;
   assign wait_more  = hold_low && (stretch_ff < cfg.stretch_limit_ticks);
   assign tmo_hit    = hold_low && !wait_more;
   assign delay_next = 17'(delay_ff) + 17'd1;
   assign fin        = timed && !wait_more && (delay_next >= {1'b0, half_eff});
   assign bit_count_inc = bit_count_ff + 4'd1;

   always_comb begin
      phase_in           = phase_ff;
      bit_count_in       = bit_count_ff;
      shift_in           = shift_ff;
      header_in          = header_ff;
      pending_payload_in = pending_payload_ff;
      pending_last_in    = pending_last_ff;
      data_mode_in       = data_mode_ff;
      open_in            = open_ff;
      delay_in           = delay_ff;
      stretch_in         = stretch_ff;
      arb_total_in       = arb_total_ff;
      arb_hit            = 1'b0;
      do_abort           = 1'b0;
      result             = '0;

      result.ready_res       = (phase_ff == PH_IDLE) || (phase_ff == PH_WAIT);
      result.stretch_expired = tmo_hit;

      // phase timing
      if (timed) begin
         if (wait_more) begin
            stretch_in = stretch_ff + 16'd1;
         end else if (fin) begin
            delay_in   = '0;
            stretch_in = '0;
         end else begin
            delay_in = DCW'(delay_next);
         end
      end

      case (phase_ff)
         PH_IDLE, PH_WAIT: begin
            if (item.req_valid) begin
               pending_payload_in = item.req_byte;
               pending_last_in    = item.req_last;
               bit_count_in       = '0;
               delay_in           = '0;
               stretch_in         = '0;
               if (phase_ff == PH_IDLE) begin
                  data_mode_in = item.func;
                  open_in      = 1'b1;
                  header_in    = HDR_ADDRESS;
                  shift_in     = {cfg.device_address, 1'b0};
                  phase_in     = PH_START_A;
               end else begin
                  header_in = HDR_PAYLOAD;
                  shift_in  = item.req_byte;
                  phase_in  = PH_BIT_LOW;
               end
            end
         end
         PH_START_A: begin
            if (fin) phase_in = PH_START_B;
         end
         PH_START_B: begin
            if (fin) begin
               phase_in = PH_START_C;
               if (!item.sda_in) begin
                  arb_hit  = 1'b1;
                  do_abort = cfg.stop_on_error;
               end
            end
         end
         PH_START_C: begin
            if (fin) begin
               bit_count_in = '0;
               phase_in     = PH_BIT_LOW;
            end
         end
         PH_BIT_LOW: begin
            if (fin) phase_in = PH_BIT_HIGH;
         end
         PH_BIT_HIGH: begin
            if (fin) begin
               if (shift_ff[7] && !item.sda_in) begin
                  arb_hit  = 1'b1;
                  do_abort = cfg.stop_on_error;
               end
               shift_in     = {shift_ff[6:0], 1'b0};
               bit_count_in = bit_count_inc;
               phase_in     = (bit_count_inc >= 4'd8) ? PH_ACK_LOW : PH_BIT_LOW;
            end
         end
         PH_ACK_LOW: begin
            if (fin) phase_in = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            if (fin) begin
               if (item.sda_in && cfg.nack_check) begin
                  result.nack_error = 1'b1;
                  do_abort          = cfg.stop_on_error;
               end
               bit_count_in = '0;
               case (header_ff)
                  HDR_ADDRESS: begin
                     header_in = HDR_CONTROL;
                     shift_in  = data_mode_ff ? CTRL_DATA : CTRL_COMMAND;
                     phase_in  = PH_BIT_LOW;
                  end
                  HDR_CONTROL: begin
                     header_in = HDR_PAYLOAD;
                     shift_in  = pending_payload_ff;
                     phase_in  = PH_BIT_LOW;
                  end
                  default: begin
                     result.byte_done = !do_abort;
                     phase_in         = pending_last_ff ? PH_STOP_A : PH_WAIT;
                  end
               endcase
            end
         end
         PH_STOP_A: begin
            if (fin) phase_in = PH_STOP_B;
         end
         PH_STOP_B: begin
            if (fin) phase_in = PH_STOP_C;
         end
         PH_STOP_C: begin
            if (fin) begin
               arb_hit  = !item.sda_in;
               do_abort = 1'b1;
            end
         end
         default: begin
            do_abort = 1'b1;
         end
      endcase

      if (arb_hit) begin
         result.arb_lost = 1'b1;
         if (arb_total_ff != ARB_COUNT_MAX) arb_total_in = arb_total_ff + 16'd1;
      end

      // abort: release the bus and close the transaction
      if (do_abort) begin
         phase_in     = PH_IDLE;
         open_in      = 1'b0;
         delay_in     = '0;
         stretch_in   = '0;
         bit_count_in = '0;
         header_in    = HDR_ADDRESS;
         shift_in     = shift_ff;
      end

      case (phase_in)
         PH_WAIT: begin
            result.scl_pull_low = 1'b1;
            result.sda_pull_low = 1'b1;
         end
         PH_START_C: result.sda_pull_low = 1'b1;
         PH_BIT_LOW: begin
            result.scl_pull_low = 1'b1;
            result.sda_pull_low = !shift_in[7];
         end
         PH_BIT_HIGH: result.sda_pull_low = !shift_in[7];
         PH_ACK_LOW: result.scl_pull_low = 1'b1;
         PH_STOP_A: begin
            result.scl_pull_low = 1'b1;
            result.sda_pull_low = 1'b1;
         end
         PH_STOP_B: result.sda_pull_low = 1'b1;
         default: ;
      endcase

      result.arb_lost_count = arb_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         bit_count_ff       <= '0;
         shift_ff           <= '0;
         header_ff          <= HDR_ADDRESS;
         pending_payload_ff <= '0;
         pending_last_ff    <= 1'b0;
         data_mode_ff       <= 1'b0;
         open_ff            <= 1'b0;
         delay_ff           <= '0;
         stretch_ff         <= '0;
         arb_total_ff       <= '0;
      end else if (step) begin
         phase_ff           <= phase_in;
         bit_count_ff       <= bit_count_in;
         shift_ff           <= shift_in;
         header_ff          <= header_in;
         pending_payload_ff <= pending_payload_in;
         pending_last_ff    <= pending_last_in;
         data_mode_ff       <= data_mode_in;
         open_ff            <= open_in;
         delay_ff           <= delay_in;
         stretch_ff         <= stretch_in;
         arb_total_ff       <= arb_total_in;
      end
   end

`ifndef SYNTHESIS
   a_open_matches_phase: assert property (@(posedge clock) disable iff (reset)
      open_ff == (phase_ff != PH_IDLE))
      else $error("transaction flag disagrees with bus phase");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd8)
      else $error("bit counter beyond one byte");

   a_arb_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> arb_total_ff >= $past(arb_total_ff))
      else $error("arbitration loss count decreased");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(delay_ff))
      else $error("engine state moved without a step");
`endif

endmodule

@@ rtl/i2c_display_command_master_unit.sv @@
// I2C display write master, one bus tick per request.
//
// Request channel (req_*): each request carries one bus tick: the byte
// request fields and the sampled SDA/SCL levels. A request is taken when
// req_push is high and req_full is low.
// Response channel (rsp_*): one response per request, in order, holding
// the line drive after that tick and the status pulses. The oldest one sits
// on rsp_data while rsp_empty is low and leaves when rsp_pop is high.
// Configuration (csr_*): write-only register file, index as listed in the
// package; write only while no request is outstanding.
//
// Flow: a request taken into the request queue is stepped by the sequencer
// once it heads that queue, and the step pushes its response into the
// response queue. Throughput: one request per cycle while the response
// queue has room. A two-entry request queue decouples the front from the
// sequencer, and a two-entry response queue decouples it from the consumer.
// Stall: while the response queue is full the sequencer holds; the request
// queue then fills and req_full rises.
// Reset: queues empty, bus released, registers at their defaults.
module i2c_display_command_master_unit
   import i2cdcm_pkg::*;
#(
   parameter int TICK_COUNTER_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  req_item_type              req_data,
   output logic                      req_full,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output rsp_item_type              rsp_data,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   req_item_type cmd_item;
   logic         cmd_empty;
   logic         cmd_full;
   rsp_item_type step_result;
   logic         rsp_full;
   logic         step;

   // decode configuration writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEVICE_ADDRESS: cfg_in.device_address      = csr_wdata[6:0];
            CSR_HALF_PERIOD:    cfg_in.half_period_ticks   = csr_wdata;
            CSR_STRETCH_LIMIT:  cfg_in.stretch_limit_ticks = csr_wdata;
            CSR_STRETCH_ENABLE: cfg_in.stretch_enable      = csr_wdata[0];
            CSR_NACK_CHECK:     cfg_in.nack_check          = csr_wdata[0];
            CSR_STOP_ON_ERROR:  cfg_in.stop_on_error       = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address      <= RESET_DEVICE_ADDRESS;
         cfg_ff.half_period_ticks   <= RESET_HALF_PERIOD;
         cfg_ff.stretch_limit_ticks <= RESET_STRETCH_LIMIT;
         cfg_ff.stretch_enable      <= 1'b0;
         cfg_ff.nack_check          <= 1'b0;
         cfg_ff.stop_on_error       <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: hold accepted requests until the sequencer takes them
   assign req_full = cmd_full;

   i2cdcm_fifo #(
      .WIDTH ($bits(req_item_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_data),
      .full      (cmd_full),
      .pop       (step),
      .pop_data  (cmd_item),
      .empty     (cmd_empty)
   );

   // advance the sequencer only when a request waits and its response fits
   assign step = !cmd_empty && !rsp_full;

   i2cdcm_engine #(
      .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (cmd_item),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   // back: park responses until the consumer pops them
   i2cdcm_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (step_result),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import i2cdcm_pkg::*;

   // Longest legal quiet spell is two idle draws plus a drain pause; allow far more.
   localparam int STALL_LIMIT = 2000;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   req_item_type              req_data = '0;
   logic                      req_full;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   rsp_item_type              rsp_data;
   logic                      csr_we = 1'b0;
   logic [2:0]                csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   i2c_display_command_master_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Shadow of the write sequencer: registers and bus state
   // ------------------------------------------------------------------
   cfg_type      cfg;
   phase_type    seq_phase;
   logic [3:0]   bits_sent;
   logic [7:0]   shifter;
   header_type   hdr;
   logic [7:0]   held_byte;
   logic         held_last;
   logic         is_data;
   logic [15:0]  tick_cnt;
   logic [15:0]  stretch_cnt;
   logic [15:0]  loss_cnt;

   // line drive and status expected for each accepted tick, oldest first
   rsp_item_type drive_forecast_q[$];

   // byte request currently on offer, and bus behaviour of the target
   logic        next_func;
   logic [7:0]  next_byte;
   logic        next_last;
   bit          offer_bytes = 1'b1;
   bit          send_idle   = 1'b1;
   bit          take_idle   = 1'b1;
   bit          stretch_on  = 1'b0;
   int          stretch_left = 0;
   int          stretch_max  = 1;

   int mismatches  = 0;
   int ticks_sent  = 0;
   int bytes_done  = 0;
   int losses      = 0;
   int timeouts    = 0;
   int nacks       = 0;
   int settings    = 0;
   int idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Sequencer prediction
   // ------------------------------------------------------------------

   // Zero half period behaves as one tick; 16-bit counters never need clipping.
   function automatic int half_ticks();
      int h;
      h = cfg.half_period_ticks;
      if (h == 0) h = 1;
      return h;
   endfunction

   // One tick of a timed phase; returns 1 once the phase has run its course.
   // A released SCL that still reads low holds the phase until the limit runs out.
   function automatic bit phase_tick(input bit released, input logic scl, inout bit tmo);
      if (released && tick_cnt == 16'd0 && cfg.stretch_enable && !scl) begin
         if (stretch_cnt >= cfg.stretch_limit_ticks) begin
            tmo = 1'b1;
         end else begin
            stretch_cnt++;
            return 1'b0;
         end
      end
      if (int'(tick_cnt) + 1 >= half_ticks()) begin
         tick_cnt    = '0;
         stretch_cnt = '0;
         return 1'b1;
      end
      tick_cnt++;
      return 1'b0;
   endfunction

   function automatic void drop_transaction();
      seq_phase   = PH_IDLE;
      tick_cnt    = '0;
      stretch_cnt = '0;
      bits_sent   = '0;
      hdr         = HDR_ADDRESS;
   endfunction

   // Count a lost arbitration (saturating); returns 1 if the transfer was dropped.
   function automatic bit count_loss(inout bit arb);
      arb = 1'b1;
      if (loss_cnt != ARB_COUNT_MAX) loss_cnt++;
      if (cfg.stop_on_error) begin
         drop_transaction();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void line_drive(output logic scl_low, output logic sda_low);
      scl_low = 1'b0;
      sda_low = 1'b0;
      case (seq_phase)
         PH_WAIT, PH_STOP_A: begin
            scl_low = 1'b1;
            sda_low = 1'b1;
         end
         PH_START_C, PH_STOP_B: sda_low = 1'b1;
         PH_BIT_LOW: begin
            scl_low = 1'b1;
            sda_low = !shifter[7];
         end
         PH_BIT_HIGH: sda_low = !shifter[7];
         PH_ACK_LOW:  scl_low = 1'b1;
         default: ;
      endcase
   endfunction

   function automatic rsp_item_type predict_tick(input req_item_type it);
      rsp_item_type r;
      bit   tmo, arb, nack, done, ready, dropped;
      logic sl, dl;
      tmo     = 1'b0;
      arb     = 1'b0;
      nack    = 1'b0;
      done    = 1'b0;
      dropped = 1'b0;
      ready   = (seq_phase == PH_IDLE || seq_phase == PH_WAIT);
      case (seq_phase)
         PH_IDLE, PH_WAIT: begin
            if (it.req_valid) begin
               held_byte   = it.req_byte;
               held_last   = it.req_last;
               bits_sent   = '0;
               tick_cnt    = '0;
               stretch_cnt = '0;
               if (seq_phase == PH_IDLE) begin
                  // open: START, address with write bit, then control byte
                  is_data   = it.func;
                  hdr       = HDR_ADDRESS;
                  shifter   = {cfg.device_address, 1'b0};
                  seq_phase = PH_START_A;
               end else begin
                  // bus already held: payload only, func is ignored
                  hdr       = HDR_PAYLOAD;
                  shifter   = it.req_byte;
                  seq_phase = PH_BIT_LOW;
               end
            end
         end
         PH_START_A: if (phase_tick(1'b0, it.scl_in, tmo)) seq_phase = PH_START_B;
         PH_START_B: begin
            if (phase_tick(1'b1, it.scl_in, tmo)) begin
               if (!it.sda_in) dropped = count_loss(arb);
               if (!dropped) seq_phase = PH_START_C;
            end
         end
         PH_START_C: begin
            if (phase_tick(1'b0, it.scl_in, tmo)) begin
               bits_sent = '0;
               seq_phase = PH_BIT_LOW;
            end
         end
         PH_BIT_LOW: if (phase_tick(1'b0, it.scl_in, tmo)) seq_phase = PH_BIT_HIGH;
         PH_BIT_HIGH: begin
            if (phase_tick(1'b1, it.scl_in, tmo)) begin
               // only a released (one) bit can lose arbitration
               if (shifter[7] && !it.sda_in) dropped = count_loss(arb);
               if (!dropped) begin
                  shifter   = shifter << 1;
                  bits_sent = bits_sent + 4'd1;
                  seq_phase = (bits_sent >= 4'd8) ? PH_ACK_LOW : PH_BIT_LOW;
               end
            end
         end
         PH_ACK_LOW: if (phase_tick(1'b0, it.scl_in, tmo)) seq_phase = PH_ACK_HIGH;
         PH_ACK_HIGH: begin
            if (phase_tick(1'b1, it.scl_in, tmo)) begin
               if (it.sda_in && cfg.nack_check) begin
                  nack = 1'b1;
                  if (cfg.stop_on_error) begin
                     drop_transaction();
                     dropped = 1'b1;
                  end
               end
               if (!dropped) begin
                  bits_sent = '0;
                  case (hdr)
                     HDR_ADDRESS: begin
                        hdr       = HDR_CONTROL;
                        shifter   = is_data ? CTRL_DATA : CTRL_COMMAND;
                        seq_phase = PH_BIT_LOW;
                     end
                     HDR_CONTROL: begin
                        hdr       = HDR_PAYLOAD;
                        shifter   = held_byte;
                        seq_phase = PH_BIT_LOW;
                     end
                     default: begin
                        done      = 1'b1;
                        seq_phase = held_last ? PH_STOP_A : PH_WAIT;
                     end
                  endcase
               end
            end
         end
         PH_STOP_A: if (phase_tick(1'b0, it.scl_in, tmo)) seq_phase = PH_STOP_B;
         PH_STOP_B: if (phase_tick(1'b1, it.scl_in, tmo)) seq_phase = PH_STOP_C;
         default: begin
            // bus free after STOP: a low SDA here is someone else's START
            if (phase_tick(1'b0, it.scl_in, tmo)) begin
               if (!it.sda_in) void'(count_loss(arb));
               drop_transaction();
            end
         end
      endcase
      line_drive(sl, dl);
      r.scl_pull_low    = sl;
      r.sda_pull_low    = dl;
      r.ready_res       = ready;
      r.byte_done       = done;
      r.nack_error      = nack;
      r.arb_lost        = arb;
      r.stretch_expired = tmo;
      r.arb_lost_count  = loss_cnt;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   function automatic void pick_request();
      next_func = $urandom_range(0, 1);
      next_byte = $urandom_range(0, 255);
      next_last = ($urandom_range(0, 2) == 0);
   endfunction

   // Build one tick as a well-behaved target would see the bus: lines follow the
   // master's drive, ACK is mostly low, and SCL is stretched now and then.
   // Noise flips the sampled levels at random to provoke losses and NACKs.
   function automatic req_item_type next_tick(input bit noisy);
      req_item_type it;
      logic sl, dl;
      line_drive(sl, dl);
      it.req_valid = offer_bytes && ($urandom_range(0, 3) != 0);
      it.func      = next_func;
      it.req_byte  = next_byte;
      it.req_last  = next_last;
      if (stretch_left > 0) begin
         it.scl_in = 1'b0;
         stretch_left--;
      end else begin
         it.scl_in = !sl;
      end
      if (stretch_on && sl && stretch_left == 0 && $urandom_range(0, 3) == 0)
         stretch_left = $urandom_range(1, stretch_max);
      if (seq_phase inside {PH_ACK_LOW, PH_ACK_HIGH})
         it.sda_in = ($urandom_range(0, 11) == 0);
      else
         it.sda_in = !dl;
      if (noisy) begin
         if ($urandom_range(0, 9) == 0) it.sda_in = $urandom_range(0, 1);
         if ($urandom_range(0, 9) == 0) it.scl_in = $urandom_range(0, 1);
      end
      return it;
   endfunction

   // Offer one tick after a random hold-off and wait for it to be taken.
   // Leaves push high at the following falling edge so back-to-back ticks stream.
   task automatic send_tick(input req_item_type it);
      rsp_item_type r;
      int gap;
      gap = send_idle ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push = 1'b1;
      req_data = it;
      do @(posedge clock); while (req_full);
      r = predict_tick(it);
      drive_forecast_q.push_back(r);
      ticks_sent++;
      bytes_done += r.byte_done;
      losses     += r.arb_lost;
      timeouts   += r.stretch_expired;
      nacks      += r.nack_error;
      if (it.req_valid && r.ready_res) pick_request();
      if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
      @(negedge clock);
   endtask

   task automatic run_ticks(input int n, input bit noisy);
      repeat (n) send_tick(next_tick(noisy));
   endtask

   // Hold off until every expected response is back and the pipe is empty.
   task automatic drain_results();
      req_push = 1'b0;
      while (drive_forecast_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      drain_results();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_DEVICE_ADDRESS: cfg.device_address      = val[6:0];
         CSR_HALF_PERIOD:    cfg.half_period_ticks   = val;
         CSR_STRETCH_LIMIT:  cfg.stretch_limit_ticks = val;
         CSR_STRETCH_ENABLE: cfg.stretch_enable      = val[0];
         CSR_NACK_CHECK:     cfg.nack_check          = val[0];
         CSR_STOP_ON_ERROR:  cfg.stop_on_error       = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
      settings++;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Field extremes, a zero half period, top address and requests while busy.
   task automatic test_directed();
      req_item_type it;
      write_reg(CSR_HALF_PERIOD, 16'd0);
      write_reg(CSR_DEVICE_ADDRESS, 16'd127);
      it = '0;
      send_tick(it);
      it = '1;
      send_tick(it);
      next_func = 1'b0;
      next_byte = 8'h00;
      next_last = 1'b0;
      run_ticks(22, 1'b0);
   endtask

   // Plain command and data traffic with NACK checking; pause mid-way for a drain.
   task automatic test_command_traffic();
      write_reg(CSR_HALF_PERIOD, 16'd1);
      write_reg(CSR_DEVICE_ADDRESS, 16'd0);
      write_reg(CSR_NACK_CHECK, 16'd1);
      run_ticks(150, 1'b0);
      drain_results();
      run_ticks(100, 1'b0);
   endtask

   // Target holds SCL low; limits of zero, short and maximum.
   task automatic test_clock_stretch();
      stretch_on  = 1'b1;
      stretch_max = 6;
      write_reg(CSR_STRETCH_ENABLE, 16'd1);
      write_reg(CSR_STRETCH_LIMIT, 16'd0);
      write_reg(CSR_HALF_PERIOD, 16'd2);
      run_ticks(120, 1'b0);
      write_reg(CSR_STRETCH_LIMIT, 16'd3);
      run_ticks(120, 1'b0);
      write_reg(CSR_STRETCH_LIMIT, 16'd65535);
      run_ticks(60, 1'b0);
      stretch_on = 1'b0;
      write_reg(CSR_STRETCH_ENABLE, 16'd0);
   endtask

   // Noisy bus with errors flagged but the sequence carrying on.
   task automatic test_error_recovery();
      write_reg(CSR_STOP_ON_ERROR, 16'd0);
      write_reg(CSR_NACK_CHECK, 16'd1);
      run_ticks(200, 1'b1);
   endtask

   // Noisy bus with errors dropping the transfer; NACKs go unchecked.
   task automatic test_error_abort();
      write_reg(CSR_STOP_ON_ERROR, 16'd1);
      write_reg(CSR_NACK_CHECK, 16'd0);
      run_ticks(150, 1'b1);
   endtask

   // Widest half period parks the sequencer in one phase; then back to a quick one.
   task automatic test_slow_bus();
      write_reg(CSR_DEVICE_ADDRESS, 16'd127);
      write_reg(CSR_HALF_PERIOD, 16'd65535);
      run_ticks(30, 1'b0);
      write_reg(CSR_HALF_PERIOD, 16'd3);
      run_ticks(100, 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Response checking
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Pop responses after random stalls and compare each with the oldest forecast.
   initial begin
      rsp_item_type want;
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = take_idle ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            rsp_pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop = 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (drive_forecast_q.size() == 0) begin
            $error("response popped with nothing expected");
            mismatches++;
         end else begin
            want = drive_forecast_q.pop_front();
            check_field("scl_pull_low",    want.scl_pull_low,    rsp_data.scl_pull_low);
            check_field("sda_pull_low",    want.sda_pull_low,    rsp_data.sda_pull_low);
            check_field("ready_res",       want.ready_res,       rsp_data.ready_res);
            check_field("byte_done",       want.byte_done,       rsp_data.byte_done);
            check_field("nack_error",      want.nack_error,      rsp_data.nack_error);
            check_field("arb_lost",        want.arb_lost,        rsp_data.arb_lost);
            check_field("stretch_expired", want.stretch_expired, rsp_data.stretch_expired);
            check_field("arb_lost_count",  want.arb_lost_count,  rsp_data.arb_lost_count);
         end
         if ($urandom_range(0, 39) == 0) take_idle = !take_idle;
         @(negedge clock);
      end
   end

   // Watchdog: give up when nothing moves on either side for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      // shadow registers and sequencer start from their reset values
      cfg.device_address      = RESET_DEVICE_ADDRESS;
      cfg.half_period_ticks   = RESET_HALF_PERIOD;
      cfg.stretch_limit_ticks = RESET_STRETCH_LIMIT;
      cfg.stretch_enable      = 1'b0;
      cfg.nack_check          = 1'b0;
      cfg.stop_on_error       = 1'b1;
      drop_transaction();
      shifter   = '0;
      held_byte = '0;
      held_last = 1'b0;
      is_data   = 1'b0;
      loss_cnt  = '0;
      pick_request();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_command_traffic();
      test_clock_stretch();
      test_error_recovery();
      test_error_abort();
      test_slow_bus();

      // wait out the last responses, then let the pipe settle
      drain_results();
      repeat (4) @(negedge clock);

      $display("Sent %0d bus ticks over %0d register writes; %0d bytes completed.",
               ticks_sent, settings, bytes_done);
      $display("Seen %0d arbitration losses, %0d NACKs and %0d stretch timeouts.",
               losses, nacks, timeouts);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
